// ===== rtl/core/wa_wirelength_gradient_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the WA wirelength gradient engine
// Shared property shapes used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef WA_WIRELENGTH_GRADIENT_MACROS_SVH
`define WA_WIRELENGTH_GRADIENT_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define WAWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wawg: same-cycle property failed");

// Next-cycle implication under the asynchronous reset.
`define WAWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wawg: next-cycle property failed");

`endif

// ===== rtl/core/wawg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wawg_pkg
// Types, codes and fixed widths shared by the WA wirelength gradient engine.
// ----------------------------------------------------------------------------
package wawg_pkg;

	typedef struct packed {
		logic signed [31:0] pin_x;
		logic signed [31:0] pin_y;
		logic [23:0]        node_id;
		logic               last_pin;
	} pin_t;

	typedef struct packed {
		logic [23:0]        out_node;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic               last_grad;
	} grad_t;

	// Register map.
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_GAMMA_RECIP = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DEGREE  = 1'd1;
	localparam logic [31:0] GAMMA_RECIP_RESET = 32'h0100_0000;
	localparam logic [6:0]  MAX_DEGREE_RESET  = 7'd64;

	// Bounding box sides.
	localparam logic [1:0] SIDE_MAX_X = 2'd0;
	localparam logic [1:0] SIDE_MIN_X = 2'd1;
	localparam logic [1:0] SIDE_MAX_Y = 2'd2;
	localparam logic [1:0] SIDE_MIN_Y = 2'd3;

	// Arithmetic widths.
	localparam int EXP_RANGE_LOG2 = 5;
	localparam int T_BITS         = 32 + EXP_RANGE_LOG2;
	localparam int WSUM_W         = 38;
	localparam int MSUM_W         = 44;
	localparam int MOM_W          = 37;
	localparam int QUOT_W         = 32;
	localparam int M24_W          = 31;
	localparam logic [31:0] ONE_Q24    = 32'h0100_0000;
	localparam logic [6:0]  M24_INT_MAX = 7'd64;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_CHECK,
		ST_S_RD,
		ST_S_T,
		ST_S_E1,
		ST_S_E2,
		ST_S_E3,
		ST_S_M,
		ST_S_ACC,
		ST_M_DIV,
		ST_M_WAIT,
		ST_E_RD,
		ST_E_T,
		ST_E_V,
		ST_E_MUL,
		ST_E_DIV,
		ST_E_WAIT,
		ST_E_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic       mem_rd;
		logic       calc_t;
		logic       exp_idx;
		logic       exp_mul;
		logic       exp_fin;
		logic       mom_mul;
		logic       acc;
		logic       w_wr;
		logic       div_start;
		logic       div_m;
		logic       m24_ld;
		logic       calc_v;
		logic       side_mul;
		logic       grad_clr;
		logic       grad_acc;
		logic       out_ld;
		logic       clear;
		logic [1:0] side;
	} wawg_cmd_t;

	typedef struct packed {
		logic net_ok;
		logic at_last;
		logic div_done;
		logic out_free;
	} wawg_status_t;

endpackage

// ===== rtl/core/wawg_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wawg_divider
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// ----------------------------------------------------------------------------
module wawg_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wawg_pkg::WSUM_W-1:0]  rem_init,
	input  logic [wawg_pkg::QUOT_W-1:0]  low,
	input  logic [wawg_pkg::WSUM_W-1:0]  divisor,
	output logic [wawg_pkg::QUOT_W-1:0]  quot,
	output logic                         done
);

	localparam int CNT_W = $clog2(wawg_pkg::QUOT_W);

	logic [wawg_pkg::WSUM_W-1:0] rem_q;
	logic [wawg_pkg::WSUM_W-1:0] div_q;
	logic [wawg_pkg::QUOT_W-1:0] low_q;
	logic [wawg_pkg::QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [wawg_pkg::WSUM_W:0]   trial;
	logic                        fits;

	// The remainder always starts below the divisor, so the quotient fits.
	assign trial = {rem_q, low_q[wawg_pkg::QUOT_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(wawg_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			low_q  <= low;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			low_q <= low_q << 1;
			if (fits) begin
				rem_q  <= wawg_pkg::WSUM_W'(trial - {1'b0, div_q});
				quot_q <= {quot_q[wawg_pkg::QUOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[wawg_pkg::WSUM_W-1:0];
				quot_q <= {quot_q[wawg_pkg::QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

// ===== rtl/core/wawg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wawg_datapath
// Pin stores, bounding box, exponential weights, sums and gradient terms.
// ----------------------------------------------------------------------------
module wawg_datapath #(
	parameter int MAX_PINS        = 64,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  wawg_pkg::pin_t                pin,
	input  logic [31:0]                   gamma_recip,
	input  logic [6:0]                    max_degree,
	input  wawg_pkg::wawg_cmd_t           cmd,
	input  logic [$clog2(MAX_PINS)-1:0]   pin_idx,
	output wawg_pkg::wawg_status_t        status,
	output logic                          grad_valid,
	input  logic                          grad_ready,
	output wawg_pkg::grad_t               grad
);

	localparam int AW = $clog2(MAX_PINS);
	localparam int CW = $clog2(MAX_PINS + 2);
	localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int TB = wawg_pkg::T_BITS;
	localparam int PW = TB + TW;
	localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

	typedef logic [31:0] exp_rom_t [0:EXP_TABLE_DEPTH];

	// e^-t samples over [0, 32] in Q1.31, built from a Q2.62 step factor.
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0]  r;
		logic [63:0]  term;
		logic [63:0]  v;
		logic [127:0] p;
		r    = Q62_ONE;
		term = Q62_ONE;
		v    = Q62_ONE;
		for (int n = 1; n <= 40; n++) begin
			if (term != 64'd0) begin
				term = term / EXP_TABLE_DEPTH * 64'd32 / 64'(n);
				if (n[0]) r = r - term;
				else r = r + term;
			end
		end
		for (int e = 0; e <= EXP_TABLE_DEPTH; e++) begin
			rom[e] = 32'((v + 64'h4000_0000) >> 31);
			p = 128'(v) * 128'(r);
			v = p[125:62];
		end
		return rom;
	endfunction

	localparam exp_rom_t ExpRom = build_exp_rom();

	function automatic logic [31:0] sat32(input logic signed [33:0] g);
		logic [31:0] res;
		if (g > 34'sd2147483647) res = 32'h7fff_ffff;
		else if (g < -34'sd2147483648) res = 32'h8000_0000;
		else res = g[31:0];
		return res;
	endfunction

	// Net state.
	logic [CW-1:0]               count_q;
	logic signed [31:0]          min_x_q, max_x_q, min_y_q, max_y_q;
	logic [wawg_pkg::WSUM_W-1:0] wsum_q [4];
	logic [wawg_pkg::MSUM_W-1:0] msum_q [4];
	logic [wawg_pkg::M24_W-1:0]  m24_q  [4];

	// Pin memories.
	logic signed [31:0] x_mem    [MAX_PINS];
	logic signed [31:0] y_mem    [MAX_PINS];
	logic [23:0]        node_mem [MAX_PINS];
	logic [3:0][31:0]   w_mem    [MAX_PINS];
	logic signed [31:0] x_rd_q, y_rd_q;
	logic [23:0]        node_rd_q;
	logic [3:0][31:0]   w_rd_q;

	// Working registers.
	logic [63:0]                t_q;
	logic [31:0]                rom_a_q, rom_b_q, frac_q;
	logic                       far_q;
	logic [63:0]                interp_q;
	logic [31:0]                a_q;
	logic [3:0][31:0]           w_q;
	logic [wawg_pkg::MOM_W-1:0] mom_q;
	logic [31:0]                mag_q;
	logic                       neg_q, zero_q;
	logic [63:0]                num_q;
	logic signed [33:0]         gx_q, gy_q;
	wawg_pkg::grad_t            grad_q;
	logic                       grad_valid_q;

	logic signed [31:0]          hi, lo;
	logic [PW-1:0]               exp_prod;
	logic [TW-1:0]               idx;
	logic [31:0]                 diff;
	logic [31:0]                 a_val;
	logic signed [33:0]          v_s;
	logic [wawg_pkg::WSUM_W-1:0] rem_init;
	logic [31:0]                 div_low;
	logic [31:0]                 quot;
	logic                        div_done;
	logic signed [33:0]          term_s;
	logic [7:0]                  qi;

	always_comb begin
		case (cmd.side)
			wawg_pkg::SIDE_MAX_X: begin
				hi = max_x_q;
				lo = x_rd_q;
			end
			wawg_pkg::SIDE_MIN_X: begin
				hi = x_rd_q;
				lo = min_x_q;
			end
			wawg_pkg::SIDE_MAX_Y: begin
				hi = max_y_q;
				lo = y_rd_q;
			end
			default: begin
				hi = y_rd_q;
				lo = min_y_q;
			end
		endcase
	end

	// Table position is t * DEPTH / 32 in Q.32; only meaningful when t < 32.
	assign exp_prod = PW'(t_q[TB-1:0]) * PW'(EXP_TABLE_DEPTH);
	assign idx      = exp_prod[TB +: TW];
	assign diff     = (rom_a_q > rom_b_q) ? rom_a_q - rom_b_q : 32'd0;
	assign a_val    = far_q ? 32'd0 : rom_a_q - interp_q[63:32];

	assign v_s = $signed(34'(wawg_pkg::ONE_Q24)) - $signed(34'(t_q[TB-1:8]))
		+ $signed(34'(m24_q[cmd.side]));

	assign rem_init = cmd.div_m ? wawg_pkg::WSUM_W'(msum_q[cmd.side] >> 8)
		: wawg_pkg::WSUM_W'(num_q[63:32]);
	assign div_low  = cmd.div_m ? {msum_q[cmd.side][7:0], 24'd0} : num_q[31:0];

	assign term_s = zero_q ? 34'sd0
		: (neg_q ? -$signed(34'(quot)) : $signed(34'(quot)));
	assign qi = quot[31:24];

	wawg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (rem_init),
		.low      (div_low),
		.divisor  (wsum_q[cmd.side]),
		.quot     (quot),
		.done     (div_done)
	);

	// Net state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			min_x_q      <= 32'sh7fff_ffff;
			max_x_q      <= 32'sh8000_0000;
			min_y_q      <= 32'sh7fff_ffff;
			max_y_q      <= 32'sh8000_0000;
			grad_valid_q <= 1'b0;
			for (int s = 0; s < 4; s++) begin
				wsum_q[s] <= '0;
				msum_q[s] <= '0;
			end
		end else begin
			if (cmd.out_ld) grad_valid_q <= 1'b1;
			else if (grad_ready) grad_valid_q <= 1'b0;

			if (cmd.clear) begin
				count_q <= '0;
				min_x_q <= 32'sh7fff_ffff;
				max_x_q <= 32'sh8000_0000;
				min_y_q <= 32'sh7fff_ffff;
				max_y_q <= 32'sh8000_0000;
				for (int s = 0; s < 4; s++) begin
					wsum_q[s] <= '0;
					msum_q[s] <= '0;
				end
			end else if (load) begin
				if (count_q <= CW'(MAX_PINS)) count_q <= count_q + CW'(1);
				if (count_q == '0) begin
					min_x_q <= pin.pin_x;
					max_x_q <= pin.pin_x;
					min_y_q <= pin.pin_y;
					max_y_q <= pin.pin_y;
				end else begin
					if (pin.pin_x < min_x_q) min_x_q <= pin.pin_x;
					if (pin.pin_x > max_x_q) max_x_q <= pin.pin_x;
					if (pin.pin_y < min_y_q) min_y_q <= pin.pin_y;
					if (pin.pin_y > max_y_q) max_y_q <= pin.pin_y;
				end
			end else if (cmd.acc) begin
				wsum_q[cmd.side] <= wsum_q[cmd.side] + wawg_pkg::WSUM_W'(a_q);
				msum_q[cmd.side] <= msum_q[cmd.side] + wawg_pkg::MSUM_W'(mom_q);
			end
		end
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (load && count_q < CW'(MAX_PINS)) begin
			x_mem[count_q[AW-1:0]]    <= pin.pin_x;
			y_mem[count_q[AW-1:0]]    <= pin.pin_y;
			node_mem[count_q[AW-1:0]] <= pin.node_id;
		end
		if (cmd.w_wr) w_mem[pin_idx] <= w_q;
		if (cmd.mem_rd) begin
			x_rd_q    <= x_mem[pin_idx];
			y_rd_q    <= y_mem[pin_idx];
			node_rd_q <= node_mem[pin_idx];
			w_rd_q    <= w_mem[pin_idx];
		end
	end

	// Arithmetic steps.
	always_ff @(posedge clk) begin
		// The edge distance is an unsigned 32-bit value, even across the full range.
		if (cmd.calc_t) t_q <= 64'($unsigned(hi - lo)) * 64'(gamma_recip);
		if (cmd.exp_idx) begin
			rom_a_q <= ExpRom[idx];
			rom_b_q <= ExpRom[idx + TW'(1)];
			frac_q  <= exp_prod[TB-1:5];
			far_q   <= |t_q[63:TB];
		end
		if (cmd.exp_mul) interp_q <= 64'(diff) * 64'(frac_q);
		if (cmd.exp_fin) begin
			a_q           <= a_val;
			w_q[cmd.side] <= a_val;
		end
		if (cmd.mom_mul) begin
			mom_q <= wawg_pkg::MOM_W'((53'(a_q) * 53'(t_q[TB-1:16])) >> 16);
		end
		if (cmd.m24_ld) begin
			m24_q[cmd.side] <= {(qi > 8'(wawg_pkg::M24_INT_MAX)) ? wawg_pkg::M24_INT_MAX
				: qi[6:0], quot[23:0]};
		end
		if (cmd.calc_v) begin
			a_q    <= w_rd_q[cmd.side];
			zero_q <= w_rd_q[cmd.side] == 32'd0;
			neg_q  <= v_s[33];
			mag_q  <= v_s[33] ? 32'(-v_s) : 32'(v_s);
		end
		if (cmd.side_mul) begin
			num_q <= 64'(a_q) * 64'(mag_q) + 64'(wsum_q[cmd.side] >> 1);
		end
		if (cmd.grad_clr) begin
			gx_q <= '0;
			gy_q <= '0;
		end else if (cmd.grad_acc) begin
			case (cmd.side)
				wawg_pkg::SIDE_MAX_X: gx_q <= gx_q + term_s;
				wawg_pkg::SIDE_MIN_X: gx_q <= gx_q - term_s;
				wawg_pkg::SIDE_MAX_Y: gy_q <= gy_q + term_s;
				default:              gy_q <= gy_q - term_s;
			endcase
		end
		if (cmd.out_ld) begin
			grad_q.out_node  <= node_rd_q;
			grad_q.grad_x    <= sat32(gx_q);
			grad_q.grad_y    <= sat32(gy_q);
			grad_q.last_grad <= status.at_last;
		end
	end

	assign status.net_ok   = (count_q > CW'(1)) && (8'(count_q) <= 8'(max_degree))
		&& (count_q <= CW'(MAX_PINS));
	assign status.at_last  = (CW'(pin_idx) + CW'(1)) == count_q;
	assign status.div_done = div_done;
	assign status.out_free = !grad_valid_q || grad_ready;

	assign grad_valid = grad_valid_q;
	assign grad       = grad_q;

endmodule

// ===== rtl/core/wawg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wawg_ctrl
// Sequencer for pin load, sum pass, moment divisions and emit pass.
// ----------------------------------------------------------------------------
module wawg_ctrl #(
	parameter int MAX_PINS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pin_valid,
	input  logic                         pin_last,
	output logic                         pin_ready,
	input  wawg_pkg::wawg_status_t       status,
	output wawg_pkg::wawg_cmd_t          cmd,
	output logic [$clog2(MAX_PINS)-1:0]  pin_idx
);

	localparam int AW = $clog2(MAX_PINS);

	wawg_pkg::ctrl_state_t state_q, state_d;
	logic [AW-1:0] pin_idx_q;
	logic [1:0]    side_q;
	logic          idx_clr, idx_inc, side_clr, side_inc;
	logic          side_end;

	assign side_end = side_q == wawg_pkg::SIDE_MIN_Y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wawg_pkg::ST_LOAD;
			pin_idx_q <= '0;
			side_q    <= wawg_pkg::SIDE_MAX_X;
		end else begin
			state_q <= state_d;
			if (idx_clr) pin_idx_q <= '0;
			else if (idx_inc) pin_idx_q <= pin_idx_q + AW'(1);
			if (side_clr) side_q <= wawg_pkg::SIDE_MAX_X;
			else if (side_inc) side_q <= side_q + 2'd1;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.side  = side_q;
		pin_ready = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		side_clr  = 1'b0;
		side_inc  = 1'b0;
		case (state_q)
			wawg_pkg::ST_LOAD: begin
				pin_ready = 1'b1;
				if (pin_valid && pin_last) state_d = wawg_pkg::ST_CHECK;
			end
			wawg_pkg::ST_CHECK: begin
				if (status.net_ok) begin
					idx_clr  = 1'b1;
					side_clr = 1'b1;
					state_d  = wawg_pkg::ST_S_RD;
				end else begin
					cmd.clear = 1'b1;
					state_d   = wawg_pkg::ST_LOAD;
				end
			end
			wawg_pkg::ST_S_RD: begin
				cmd.mem_rd = 1'b1;
				side_clr   = 1'b1;
				state_d    = wawg_pkg::ST_S_T;
			end
			wawg_pkg::ST_S_T: begin
				cmd.calc_t = 1'b1;
				state_d    = wawg_pkg::ST_S_E1;
			end
			wawg_pkg::ST_S_E1: begin
				cmd.exp_idx = 1'b1;
				state_d     = wawg_pkg::ST_S_E2;
			end
			wawg_pkg::ST_S_E2: begin
				cmd.exp_mul = 1'b1;
				state_d     = wawg_pkg::ST_S_E3;
			end
			wawg_pkg::ST_S_E3: begin
				cmd.exp_fin = 1'b1;
				state_d     = wawg_pkg::ST_S_M;
			end
			wawg_pkg::ST_S_M: begin
				cmd.mom_mul = 1'b1;
				state_d     = wawg_pkg::ST_S_ACC;
			end
			wawg_pkg::ST_S_ACC: begin
				cmd.acc = 1'b1;
				if (side_end) begin
					cmd.w_wr = 1'b1;
					side_clr = 1'b1;
					if (status.at_last) begin
						state_d = wawg_pkg::ST_M_DIV;
					end else begin
						idx_inc = 1'b1;
						state_d = wawg_pkg::ST_S_RD;
					end
				end else begin
					side_inc = 1'b1;
					state_d  = wawg_pkg::ST_S_T;
				end
			end
			wawg_pkg::ST_M_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_m     = 1'b1;
				state_d       = wawg_pkg::ST_M_WAIT;
			end
			wawg_pkg::ST_M_WAIT: begin
				cmd.div_m = 1'b1;
				if (status.div_done) begin
					cmd.m24_ld = 1'b1;
					if (side_end) begin
						idx_clr = 1'b1;
						state_d = wawg_pkg::ST_E_RD;
					end else begin
						side_inc = 1'b1;
						state_d  = wawg_pkg::ST_M_DIV;
					end
				end
			end
			wawg_pkg::ST_E_RD: begin
				cmd.mem_rd   = 1'b1;
				cmd.grad_clr = 1'b1;
				side_clr     = 1'b1;
				state_d      = wawg_pkg::ST_E_T;
			end
			wawg_pkg::ST_E_T: begin
				cmd.calc_t = 1'b1;
				state_d    = wawg_pkg::ST_E_V;
			end
			wawg_pkg::ST_E_V: begin
				cmd.calc_v = 1'b1;
				state_d    = wawg_pkg::ST_E_MUL;
			end
			wawg_pkg::ST_E_MUL: begin
				cmd.side_mul = 1'b1;
				state_d      = wawg_pkg::ST_E_DIV;
			end
			wawg_pkg::ST_E_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = wawg_pkg::ST_E_WAIT;
			end
			wawg_pkg::ST_E_WAIT: begin
				if (status.div_done) begin
					cmd.grad_acc = 1'b1;
					if (side_end) begin
						state_d = wawg_pkg::ST_E_OUT;
					end else begin
						side_inc = 1'b1;
						state_d  = wawg_pkg::ST_E_T;
					end
				end
			end
			wawg_pkg::ST_E_OUT: begin
				if (status.out_free) begin
					cmd.out_ld = 1'b1;
					if (status.at_last) begin
						cmd.clear = 1'b1;
						state_d   = wawg_pkg::ST_LOAD;
					end else begin
						idx_inc = 1'b1;
						state_d = wawg_pkg::ST_E_RD;
					end
				end
			end
			default: state_d = wawg_pkg::ST_LOAD;
		endcase
	end

	assign pin_idx = pin_idx_q;

endmodule

// ===== rtl/core/wa_wirelength_gradient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wa_wirelength_gradient
// Weighted-average wirelength gradient engine for one net at a time.
// ----------------------------------------------------------------------------
// The pin channel (pin_valid/pin_ready/pin) takes the pins of a net, one per
// cycle, the last one flagged by last_pin. Each pin is stored and widens the
// bounding box. After the last pin the block stops taking pins, makes a sum
// pass over the stored pins, four moment divisions and an emit pass over
// the pins again. One gradient transaction leaves on grad_valid/grad_ready
// per pin, in arrival order, last_grad set on the final one. The shared
// bit-serial divider does the four moment divisions and four divisions per
// pin in the emit pass. Nets of one pin or above max_net_degree give no
// transactions and hold pin_ready low for one cycle after the last pin.
// If the receiver stalls, the emit pass waits with the next result held
// back; the final result may wait in the output register while the next
// net's pins are already taken. Reset empties the net state, drops any
// pending result and restores the gamma reciprocal to 1.0 and max_net_degree
// to 64.
// ----------------------------------------------------------------------------
module wa_wirelength_gradient #(
	parameter int MAX_PINS        = 64,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pin_valid,
	output logic                              pin_ready,
	input  wawg_pkg::pin_t                    pin,
	output logic                              grad_valid,
	input  logic                              grad_ready,
	output wawg_pkg::grad_t                   grad,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wawg_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [31:0]                      gamma_recip_q;
	logic [6:0]                       max_degree_q;
	logic [wawg_pkg::REG_IDX_W-1:0]   reg_idx;
	logic                             cfg_wr;
	wawg_pkg::wawg_cmd_t              cmd;
	wawg_pkg::wawg_status_t           status;
	logic [$clog2(MAX_PINS)-1:0]      pin_idx;

	assign reg_idx = paddr[wawg_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_recip_q <= wawg_pkg::GAMMA_RECIP_RESET;
			max_degree_q  <= wawg_pkg::MAX_DEGREE_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				wawg_pkg::REG_GAMMA_RECIP: gamma_recip_q <= pwdata;
				wawg_pkg::REG_MAX_DEGREE:  max_degree_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wawg_pkg::REG_GAMMA_RECIP: prdata = gamma_recip_q;
			wawg_pkg::REG_MAX_DEGREE:  prdata = 32'(max_degree_q);
			default:                   prdata = 32'd0;
		endcase
	end

	wawg_ctrl #(
		.MAX_PINS (MAX_PINS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pin_valid (pin_valid),
		.pin_last  (pin.last_pin),
		.pin_ready (pin_ready),
		.status    (status),
		.cmd       (cmd),
		.pin_idx   (pin_idx)
	);

	wawg_datapath #(
		.MAX_PINS        (MAX_PINS),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (pin_valid && pin_ready),
		.pin         (pin),
		.gamma_recip (gamma_recip_q),
		.max_degree  (max_degree_q),
		.cmd         (cmd),
		.pin_idx     (pin_idx),
		.status      (status),
		.grad_valid  (grad_valid),
		.grad_ready  (grad_ready),
		.grad        (grad)
	);

endmodule

// ===== rtl/core/wawg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wawg_checker
// Port-level checks of the WA wirelength gradient engine.
// ----------------------------------------------------------------------------
`include "wa_wirelength_gradient_macros.svh"

module wawg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             pin_valid,
	input logic                             pin_ready,
	input wawg_pkg::pin_t                   pin,
	input logic                             grad_valid,
	input logic                             grad_ready,
	input wawg_pkg::grad_t                  grad,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [wawg_pkg::APB_ADDR_W-1:0]  paddr,
	input logic [31:0]                      pwdata,
	input logic [31:0]                      prdata,
	input logic                             pready
);

	logic recip_wr;

	assign recip_wr = psel && penable && pwrite && pready && !paddr[2];

	// A stalled gradient transaction holds.
	`WAWG_ASSERT_NXT(a_grad_hold, clk, arst_n, grad_valid && !grad_ready, grad_valid && $stable(grad))

	// A waiting pin transaction holds until it is taken.
	`WAWG_ASSERT_NXT(a_pin_hold, clk, arst_n, pin_valid && !pin_ready, pin_valid && $stable(pin))

	// While a net is still being emitted, no new pins are taken.
	`WAWG_ASSERT_IMP(a_no_pin_mid_net, clk, arst_n, grad_valid && !grad.last_grad, !pin_ready)

	// A write to the gamma reciprocal register reads back on the next cycle.
	`WAWG_ASSERT_NXT(a_recip_readback, clk, arst_n, recip_wr, paddr[2] || prdata == $past(pwdata))

endmodule

bind wa_wirelength_gradient wawg_checker u_wawg_checker (.*);
